FILE: rtl/core/poram_pkg.sv
// Shared constants, types and path-index helpers for the path ORAM block.
`default_nettype none
package poram_pkg;

	localparam int TREE_LEVELS  = 5;
	localparam int BUCKET_SLOTS = 4;
	localparam int BLOCK_COUNT  = 16;
	localparam int STASH_DEPTH  = 64;
	localparam int DATA_WIDTH   = 32;

	localparam int LEAF_W       = TREE_LEVELS - 1;
	localparam int BUCKET_COUNT = (1 << TREE_LEVELS) - 1;
	localparam int SLOT_COUNT   = BUCKET_COUNT * BUCKET_SLOTS;
	localparam int SLOT_AW      = $clog2(SLOT_COUNT);
	localparam int BLK_W        = $clog2(BLOCK_COUNT);
	localparam int FILL_W       = $clog2(STASH_DEPTH + 1);
	localparam int SIDX_W       = $clog2(STASH_DEPTH);
	localparam int LVL_W        = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;
	localparam int PLC_W        = $clog2(BUCKET_SLOTS + 1);

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// one stash entry; leaf caches the position map of blk
	typedef struct packed {
		logic                  vld;
		logic [BLK_W-1:0]      blk;
		logic [LEAF_W-1:0]     leaf;
		logic [DATA_WIDTH-1:0] data;
	} stash_ent_t;

	// stash chain control: shift the row, load one cell at wptr
	typedef struct packed {
		logic              shift;
		logic              load;
		logic [SIDX_W-1:0] wptr;
	} stash_ctl_t;

	typedef struct packed {
		logic [BLK_W-1:0]      blk;
		logic [DATA_WIDTH-1:0] data;
	} slot_t;

	// slot address of slot s in the bucket of level lvl on the path to leaf
	function automatic logic [SLOT_AW-1:0] slot_addr(input logic [LEAF_W-1:0] leaf,
			input logic [LVL_W-1:0] lvl, input logic [PLC_W-1:0] s);
		int b;
		b = ((1 << lvl) - 1) + int'(leaf >> (LEAF_W - int'(lvl)));
		return SLOT_AW'(b * BUCKET_SLOTS + int'(s));
	endfunction

	// both leaves pass through the same bucket at level lvl
	function automatic logic same_bucket(input logic [LEAF_W-1:0] a,
			input logic [LEAF_W-1:0] b, input logic [LVL_W-1:0] lvl);
		return (a >> (LEAF_W - int'(lvl))) == (b >> (LEAF_W - int'(lvl)));
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/poram_req_if.sv
// Request channel: access word with valid/ready handshake.
`default_nettype none
interface poram_req_if import poram_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  opcode;
	logic [3:0]            block_index;
	logic [3:0]            new_leaf;
	logic [DATA_WIDTH-1:0] write_data;

	modport source (output valid, opcode, block_index, new_leaf, write_data, input ready);
	modport sink   (input valid, opcode, block_index, new_leaf, write_data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/poram_rsp_if.sv
// Response channel: result word with valid/ready handshake.
`default_nettype none
interface poram_rsp_if import poram_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] read_data;
	logic                  found;
	logic [6:0]            stash_count;
	logic                  stash_overflow;

	modport source (output valid, read_data, found, stash_count, stash_overflow, input ready);
	modport sink   (input valid, read_data, found, stash_count, stash_overflow, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/path_oram_access.sv
// Path ORAM access controller: tree store, position map, stash chain and sequencer.
//
// Requests enter on req (opcode, block_index, new_leaf, write_data) and each
// produces one result word on rsp (read_data, found, stash_count,
// stash_overflow). One access is in flight at a time; req.ready is high only
// while the sequencer is idle.
// The path is read one slot per cycle through the tree memory port,
// after which the read pipeline drains. Then the stash row makes one full
// rotation to serve the request and one full rotation per level to evict.
// Each rotation streams every cell past the head once, in stash order, and
// compacts the kept entries in the same pass.
// The result sits in an output register; the next request may be accepted
// while it waits. If the receiver stalls, the sequencer holds its next result
// in the final step until the register frees.
// Reset empties the tree and stash and maps every block to leaf 0; no
// clearing pass is needed.
`default_nettype none
module path_oram_access import poram_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	poram_req_if.sink   req,
	poram_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_SERVE, S_APPEND, S_EVICT, S_RESP
	} state_t;

	state_t                state_q;
	logic                  op_q;
	logic [BLK_W-1:0]      blk_q;
	logic [LEAF_W-1:0]     fresh_q;
	logic [DATA_WIDTH-1:0] wdata_q;
	logic [LEAF_W-1:0]     old_leaf_q;
	logic                  found_q;
	logic [DATA_WIDTH-1:0] rdata_q;
	logic                  ovf_q;
	logic [FILL_W-1:0]     fill_q;
	logic [LVL_W-1:0]      lvl_q;
	logic [PLC_W-1:0]      slot_q;
	logic                  issue_q;
	logic                  rd_vld_s1;
	logic                  sv_s1;
	logic [SIDX_W-1:0]     pass_q;
	logic [SIDX_W-1:0]     wptr_q;
	logic [FILL_W-1:0]     kept_q;
	logic [PLC_W-1:0]      placed_q;
	logic                  out_vld_q;
	logic [DATA_WIDTH-1:0] out_data_q;
	logic                  out_found_q;
	logic [6:0]            out_count_q;
	logic                  out_ovf_q;

	logic [LEAF_W-1:0]     leaf_map_q [BLOCK_COUNT];
	logic                  slot_valid_q [SLOT_COUNT];
	slot_t                 tree_mem [SLOT_COUNT];
	slot_t                 mem_rd_s1;

	stash_ctl_t            sctl;
	stash_ent_t            sdata;
	stash_ent_t            head;

	logic                  accept;
	logic                  in_range;
	logic [SLOT_AW-1:0]    rd_addr;
	logic [SLOT_AW-1:0]    wr_addr;
	logic [BLK_W-1:0]      lm_addr;
	logic [LEAF_W-1:0]     lm_leaf;
	logic                  push_ok;
	logic                  hit;
	logic                  pick;
	logic                  keep;
	logic                  pass_end;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_range  = int'(req.block_index) < BLOCK_COUNT;

	// path addressing and position map lookup
	assign rd_addr  = slot_addr(old_leaf_q, lvl_q, slot_q);
	assign wr_addr  = slot_addr(old_leaf_q, lvl_q, placed_q);
	assign lm_addr  = (state_q == S_READ) ? mem_rd_s1.blk : req.block_index[BLK_W-1:0];
	assign lm_leaf  = leaf_map_q[lm_addr];
	assign push_ok  = int'(fill_q) < STASH_DEPTH;
	assign pass_end = (pass_q == SIDX_W'(STASH_DEPTH - 1));

	// head decisions during rotations
	assign hit  = head.vld && (head.blk == blk_q);
	assign pick = (state_q == S_EVICT) && head.vld && (int'(placed_q) < BUCKET_SLOTS)
		&& same_bucket(head.leaf, old_leaf_q, lvl_q);
	assign keep = head.vld && !pick;

	// drive the stash row
	always_comb begin
		sctl  = '0;
		sdata = head;
		unique case (state_q)
			S_READ: begin
				sctl.load = rd_vld_s1 && sv_s1 && push_ok;
				sctl.wptr = fill_q[SIDX_W-1:0];
				sdata     = '{vld: 1'b1, blk: mem_rd_s1.blk, leaf: lm_leaf,
					data: mem_rd_s1.data};
			end
			S_APPEND: begin
				sctl.load = (op_q == OP_WRITE) && !found_q && push_ok;
				sctl.wptr = fill_q[SIDX_W-1:0];
				sdata     = '{vld: 1'b1, blk: blk_q, leaf: fresh_q, data: wdata_q};
			end
			S_SERVE: begin
				sctl.shift = 1'b1;
				sctl.load  = head.vld;
				sctl.wptr  = wptr_q;
				if (hit) begin
					sdata.leaf = fresh_q;
					if (op_q == OP_WRITE && !found_q) begin
						sdata.data = wdata_q;
					end
				end
			end
			S_EVICT: begin
				sctl.shift = 1'b1;
				sctl.load  = keep;
				sctl.wptr  = wptr_q;
			end
			default: begin
				sctl = '0;
			end
		endcase
	end

	poram_stash u_stash (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (sctl),
		.load_data (sdata),
		.head      (head)
	);

	// position map: remap the accessed block on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BLOCK_COUNT; i++) begin
				leaf_map_q[i] <= '0;
			end
		end else if (accept && in_range) begin
			leaf_map_q[req.block_index[BLK_W-1:0]] <= req.new_leaf[LEAF_W-1:0];
		end
	end

	// slot valid bits: drop on path read, set on eviction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_valid_q[i] <= 1'b0;
			end
		end else if (state_q == S_READ && issue_q) begin
			slot_valid_q[rd_addr] <= 1'b0;
		end else if (pick) begin
			slot_valid_q[wr_addr] <= 1'b1;
		end
	end

	// tree memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (pick) begin
			tree_mem[wr_addr] <= '{blk: head.blk, data: head.data};
		end
		mem_rd_s1 <= tree_mem[rd_addr];
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_READ;
			blk_q       <= '0;
			fresh_q     <= '0;
			wdata_q     <= '0;
			old_leaf_q  <= '0;
			found_q     <= 1'b0;
			rdata_q     <= '0;
			ovf_q       <= 1'b0;
			fill_q      <= '0;
			lvl_q       <= '0;
			slot_q      <= '0;
			issue_q     <= 1'b0;
			rd_vld_s1   <= 1'b0;
			sv_s1       <= 1'b0;
			pass_q      <= '0;
			wptr_q      <= '0;
			kept_q      <= '0;
			placed_q    <= '0;
			out_vld_q   <= 1'b0;
			out_data_q  <= '0;
			out_found_q <= 1'b0;
			out_count_q <= '0;
			out_ovf_q   <= 1'b0;
		end else begin
			// drop the taken word unless the final step refills it
			if (rsp.valid && rsp.ready && state_q != S_RESP) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q       <= req.opcode;
						blk_q      <= req.block_index[BLK_W-1:0];
						fresh_q    <= req.new_leaf[LEAF_W-1:0];
						wdata_q    <= req.write_data;
						old_leaf_q <= lm_leaf;
						found_q    <= 1'b0;
						rdata_q    <= '0;
						ovf_q      <= 1'b0;
						lvl_q      <= '0;
						slot_q     <= '0;
						issue_q    <= in_range;
						state_q    <= in_range ? S_READ : S_RESP;
					end
				end
				S_READ: begin
					// issue slot reads root first, consume them from the read register
					rd_vld_s1 <= issue_q;
					sv_s1     <= slot_valid_q[rd_addr];
					if (issue_q) begin
						if (int'(slot_q) == BUCKET_SLOTS - 1) begin
							slot_q <= '0;
							if (int'(lvl_q) == TREE_LEVELS - 1) begin
								issue_q <= 1'b0;
							end else begin
								lvl_q <= lvl_q + 1'b1;
							end
						end else begin
							slot_q <= slot_q + 1'b1;
						end
					end
					if (rd_vld_s1 && sv_s1) begin
						if (push_ok) begin
							fill_q <= fill_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
					end
					if (!issue_q && !rd_vld_s1) begin
						pass_q  <= '0;
						wptr_q  <= SIDX_W'(STASH_DEPTH - 1);
						state_q <= S_SERVE;
					end
				end
				S_SERVE: begin
					if (hit && !found_q) begin
						found_q <= 1'b1;
						rdata_q <= head.data;
					end
					if (!head.vld) begin
						wptr_q <= wptr_q - 1'b1;
					end
					pass_q <= pass_q + 1'b1;
					if (pass_end) begin
						state_q <= S_APPEND;
					end
				end
				S_APPEND: begin
					if (op_q == OP_WRITE && !found_q) begin
						if (push_ok) begin
							fill_q <= fill_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
					end
					lvl_q    <= LVL_W'(TREE_LEVELS - 1);
					pass_q   <= '0;
					wptr_q   <= SIDX_W'(STASH_DEPTH - 1);
					kept_q   <= '0;
					placed_q <= '0;
					state_q  <= S_EVICT;
				end
				S_EVICT: begin
					// one rotation per level, leaf to root
					if (pass_end) begin
						fill_q   <= kept_q + FILL_W'(keep);
						kept_q   <= '0;
						placed_q <= '0;
						pass_q   <= '0;
						wptr_q   <= SIDX_W'(STASH_DEPTH - 1);
						if (lvl_q == '0) begin
							state_q <= S_RESP;
						end else begin
							lvl_q <= lvl_q - 1'b1;
						end
					end else begin
						if (pick) begin
							placed_q <= placed_q + 1'b1;
						end
						if (keep) begin
							kept_q <= kept_q + 1'b1;
						end else begin
							wptr_q <= wptr_q - 1'b1;
						end
						pass_q <= pass_q + 1'b1;
					end
				end
				S_RESP: begin
					if (!out_vld_q || rsp.ready) begin
						out_vld_q   <= 1'b1;
						out_data_q  <= rdata_q;
						out_found_q <= found_q;
						out_count_q <= 7'(fill_q);
						out_ovf_q   <= ovf_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.read_data      = out_data_q;
	assign rsp.found          = out_found_q;
	assign rsp.stash_count    = out_count_q;
	assign rsp.stash_overflow = out_ovf_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= STASH_DEPTH)
		else $error("stash occupancy above depth");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> int'($past(fill_q)) == STASH_DEPTH)
		else $error("overflow flagged with room in stash");

	a_resp_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RESP |-> !issue_q && !rd_vld_s1)
		else $error("result taken while path reads pending");

	a_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !found_q && !ovf_q && rdata_q == '0)
		else $error("access flags not cleared on accept");

endmodule
`default_nettype wire

FILE: rtl/core/poram_cell.sv
// One stash cell: holds an entry, takes its neighbor's on shift or a new one on load.
`default_nettype none
module poram_cell import poram_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       shift,
	input  wire logic       load,
	input  wire stash_ent_t nbr,
	input  wire stash_ent_t load_data,
	output stash_ent_t      ent
);

	logic                  vld_q;
	logic [BLK_W-1:0]      blk_q;
	logic [LEAF_W-1:0]     leaf_q;
	logic [DATA_WIDTH-1:0] data_q;

	// track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= load_data.vld;
		end else if (shift) begin
			vld_q <= nbr.vld;
		end
	end

	// hold entry contents
	always_ff @(posedge clk) begin
		if (load) begin
			blk_q  <= load_data.blk;
			leaf_q <= load_data.leaf;
			data_q <= load_data.data;
		end else if (shift) begin
			blk_q  <= nbr.blk;
			leaf_q <= nbr.leaf;
			data_q <= nbr.data;
		end
	end

	assign ent = '{vld: vld_q, blk: blk_q, leaf: leaf_q, data: data_q};

endmodule
`default_nettype wire

FILE: rtl/core/poram_stash.sv
// Stash as a row of cells shifting toward the head, with a loadable cell at wptr.
`default_nettype none
module poram_stash import poram_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire stash_ctl_t ctl,
	input  wire stash_ent_t load_data,
	output stash_ent_t      head
);

	stash_ent_t ent [STASH_DEPTH+1];

	// an empty entry enters behind the last cell
	assign ent[STASH_DEPTH] = '0;

	for (genvar i = 0; i < STASH_DEPTH; i++) begin : g_cell
		logic sel;

		assign sel = ctl.load && (ctl.wptr == SIDX_W'(i));

		poram_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (ctl.shift),
			.load      (sel),
			.nbr       (ent[i+1]),
			.load_data (load_data),
			.ent       (ent[i])
		);
	end

	assign head = ent[0];

endmodule
`default_nettype wire
